FILE: rtl/core/gwm_pkg.sv
// ----------------------------------------------------------------------------
// Glyph width measure package
// Shared constants, types and helper functions of the glyph width block.
// ----------------------------------------------------------------------------
package gwm_pkg;

	localparam int CELLS      = 16;
	localparam int CELL_AW    = 4;
	localparam int GLYPH_W    = 7;
	localparam int ROW_W      = CELLS * GLYPH_W;
	localparam int INNER_W    = 6;
	localparam int SUM_W      = 16;

	localparam logic [6:0]       MAX_CELL   = 7'd64;
	localparam logic [6:0]       RESET_CELL = 7'd16;
	localparam logic [7:0]       SPACE_CODE = 8'd32;
	localparam logic [SUM_W-1:0] SAT16      = 16'hFFFF;

	localparam logic OP_ATLAS   = 1'b0;
	localparam logic OP_TEXT    = 1'b1;
	localparam logic KIND_ATLAS = 1'b0;
	localparam logic KIND_TEXT  = 1'b1;

	typedef struct packed {
		logic               we;
		logic [CELL_AW-1:0] addr;
		logic [ROW_W-1:0]   data;
	} gwm_row_wr_t;

	typedef struct packed {
		logic               loaded;
		logic [6:0]         height;
		logic               space_ovr;
		logic [GLYPH_W-1:0] space_w;
		logic [CELLS-1:0]   row_valid;
	} gwm_atlas_stat_t;

	typedef struct packed {
		logic             kind;
		logic [SUM_W-1:0] total_width;
		logic [SUM_W-1:0] fit_count;
		logic [6:0]       line_height;
		logic             loaded;
	} gwm_result_t;

	function automatic logic [6:0] eff_cell(input logic [6:0] cs);
		logic [6:0] r;
		if (cs == 7'd0) begin
			r = 7'd1;
		end else if (cs > MAX_CELL) begin
			r = MAX_CELL;
		end else begin
			r = cs;
		end
		return r;
	endfunction

	// Exact floor(n / 3) for n up to 64 by reciprocal multiplication.
	function automatic logic [GLYPH_W-1:0] div3(input logic [6:0] n);
		logic [14:0] p;
		p = {8'd0, n} * 15'd171;
		return {1'b0, p[14:9]};
	endfunction

endpackage

FILE: rtl/core/gwm_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gwm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/core/gwm_atlas.sv
// ----------------------------------------------------------------------------
// Atlas scanner
// Walks the atlas in raster order, tracks the inked column span of each cell
// and emits one row of glyph widths when a cell row completes.
// ----------------------------------------------------------------------------
module gwm_atlas (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [6:0]               cfg_wdata,
	input  logic                     fire,
	input  logic [7:0]               alpha,
	output gwm_pkg::gwm_row_wr_t     row_wr,
	output logic                     done,
	output logic [6:0]               step,
	output gwm_pkg::gwm_atlas_stat_t stat
);

	logic [6:0]                   cell_size_q;
	logic [6:0]                   step_m1_full;
	logic [gwm_pkg::INNER_W-1:0]  step_m1;
	logic [gwm_pkg::INNER_W-1:0]  inner_q;
	logic [gwm_pkg::CELL_AW-1:0]  cx_q;
	logic [gwm_pkg::INNER_W-1:0]  rin_q;
	logic [gwm_pkg::CELL_AW-1:0]  cy_q;
	logic [gwm_pkg::INNER_W-1:0]  left_q  [gwm_pkg::CELLS];
	logic [gwm_pkg::INNER_W-1:0]  right_q [gwm_pkg::CELLS];
	logic [gwm_pkg::CELLS-1:0]    seen_q;
	logic [gwm_pkg::INNER_W-1:0]  left_n  [gwm_pkg::CELLS];
	logic [gwm_pkg::INNER_W-1:0]  right_n [gwm_pkg::CELLS];
	logic [gwm_pkg::CELLS-1:0]    seen_n;
	logic                         inner_last;
	logic                         col_last;
	logic                         rin_last;
	logic                         row_end;
	logic [gwm_pkg::ROW_W-1:0]    row_data;
	logic                         loaded_q;
	logic [6:0]                   height_q;
	logic                         space_ovr_q;
	logic [gwm_pkg::GLYPH_W-1:0]  space_w_q;
	logic [gwm_pkg::CELLS-1:0]    row_valid_q;

	assign step         = gwm_pkg::eff_cell(cell_size_q);
	assign step_m1_full = step - 7'd1;
	assign step_m1      = step_m1_full[gwm_pkg::INNER_W-1:0];
	assign inner_last   = (inner_q == step_m1);
	assign col_last     = inner_last && (cx_q == gwm_pkg::CELL_AW'(gwm_pkg::CELLS - 1));
	assign rin_last     = (rin_q == step_m1);
	assign row_end      = col_last && rin_last;
	assign done         = row_end && (cy_q == gwm_pkg::CELL_AW'(gwm_pkg::CELLS - 1));

	always_comb begin
		left_n  = left_q;
		right_n = right_q;
		seen_n  = seen_q;
		if (alpha != 8'd0) begin
			if (!seen_q[cx_q]) begin
				seen_n[cx_q]  = 1'b1;
				left_n[cx_q]  = inner_q;
				right_n[cx_q] = inner_q;
			end else begin
				if (inner_q < left_q[cx_q]) begin
					left_n[cx_q] = inner_q;
				end
				if (inner_q > right_q[cx_q]) begin
					right_n[cx_q] = inner_q;
				end
			end
		end
	end

	always_comb begin
		for (int x = 0; x < gwm_pkg::CELLS; x++) begin
			if (seen_n[x]) begin
				row_data[x*gwm_pkg::GLYPH_W +: gwm_pkg::GLYPH_W] =
					{1'b0, right_n[x] - left_n[x]} + 7'd1;
			end else begin
				row_data[x*gwm_pkg::GLYPH_W +: gwm_pkg::GLYPH_W] = '0;
			end
		end
	end

	assign row_wr.we   = fire && row_end;
	assign row_wr.addr = cy_q;
	assign row_wr.data = row_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_size_q <= gwm_pkg::RESET_CELL;
			inner_q     <= '0;
			cx_q        <= '0;
			rin_q       <= '0;
			cy_q        <= '0;
			seen_q      <= '0;
			for (int x = 0; x < gwm_pkg::CELLS; x++) begin
				left_q[x]  <= '0;
				right_q[x] <= '0;
			end
		end else if (cfg_we) begin
			cell_size_q <= cfg_wdata;
			inner_q     <= '0;
			cx_q        <= '0;
			rin_q       <= '0;
			cy_q        <= '0;
			seen_q      <= '0;
			for (int x = 0; x < gwm_pkg::CELLS; x++) begin
				left_q[x]  <= '0;
				right_q[x] <= '0;
			end
		end else if (fire) begin
			if (row_end) begin
				seen_q <= '0;
				for (int x = 0; x < gwm_pkg::CELLS; x++) begin
					left_q[x]  <= '0;
					right_q[x] <= '0;
				end
			end else begin
				seen_q  <= seen_n;
				left_q  <= left_n;
				right_q <= right_n;
			end
			if (col_last) begin
				inner_q <= '0;
				cx_q    <= '0;
				if (rin_last) begin
					rin_q <= '0;
					cy_q  <= cy_q + 4'd1;
				end else begin
					rin_q <= rin_q + 6'd1;
				end
			end else if (inner_last) begin
				inner_q <= '0;
				cx_q    <= cx_q + 4'd1;
			end else begin
				inner_q <= inner_q + 6'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q    <= 1'b0;
			height_q    <= '0;
			space_ovr_q <= 1'b0;
			space_w_q   <= '0;
			row_valid_q <= '0;
		end else if (fire) begin
			if (row_end) begin
				row_valid_q[cy_q] <= 1'b1;
				if (cy_q == gwm_pkg::SPACE_CODE[7:4]) begin
					space_ovr_q <= 1'b0;
				end
			end
			if (done) begin
				loaded_q    <= 1'b1;
				height_q    <= step;
				space_ovr_q <= 1'b1;
				space_w_q   <= gwm_pkg::div3(step);
			end
		end
	end

	assign stat.loaded    = loaded_q;
	assign stat.height    = height_q;
	assign stat.space_ovr = space_ovr_q;
	assign stat.space_w   = space_w_q;
	assign stat.row_valid = row_valid_q;

endmodule

FILE: rtl/core/gwm_measure.sv
// ----------------------------------------------------------------------------
// String measurer
// Accumulates glyph widths of a string and the count of characters that fit
// within the bound taken at the first character.
// ----------------------------------------------------------------------------
module gwm_measure (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  logic                        first_char,
	input  logic [gwm_pkg::SUM_W-1:0]   bound,
	input  logic [gwm_pkg::GLYPH_W-1:0] glyph_width,
	input  logic                        loaded,
	input  logic [6:0]                  height,
	output gwm_pkg::gwm_result_t        result
);

	logic [gwm_pkg::SUM_W-1:0] width_sum_q;
	logic [gwm_pkg::SUM_W-1:0] fit_sum_q;
	logic [gwm_pkg::SUM_W-1:0] fit_index_q;
	logic                      fit_stopped_q;
	logic [gwm_pkg::SUM_W-1:0] held_bound_q;
	logic [gwm_pkg::SUM_W-1:0] ws_b;
	logic [gwm_pkg::SUM_W-1:0] fs_b;
	logic [gwm_pkg::SUM_W-1:0] fi_b;
	logic                      stop_b;
	logic [gwm_pkg::SUM_W-1:0] hb_b;
	logic [gwm_pkg::SUM_W:0]   ws_add;
	logic [gwm_pkg::SUM_W:0]   fs_add;
	logic [gwm_pkg::SUM_W-1:0] ws_n;
	logic [gwm_pkg::SUM_W-1:0] fs_n;
	logic [gwm_pkg::SUM_W-1:0] fi_n;
	logic                      stop_n;
	logic [gwm_pkg::SUM_W-1:0] count;

	always_comb begin
		if (first_char) begin
			ws_b   = '0;
			fs_b   = '0;
			fi_b   = '0;
			stop_b = 1'b0;
			hb_b   = bound;
		end else begin
			ws_b   = width_sum_q;
			fs_b   = fit_sum_q;
			fi_b   = fit_index_q;
			stop_b = fit_stopped_q;
			hb_b   = held_bound_q;
		end
		ws_add = {1'b0, ws_b} + {10'd0, glyph_width};
		fs_add = {1'b0, fs_b} + {10'd0, glyph_width};
		ws_n   = ws_add[gwm_pkg::SUM_W] ? gwm_pkg::SAT16 : ws_add[gwm_pkg::SUM_W-1:0];
		fs_n   = fs_b;
		fi_n   = fi_b;
		stop_n = stop_b;
		if (!stop_b) begin
			if (fs_b < hb_b) begin
				fs_n = fs_add[gwm_pkg::SUM_W] ? gwm_pkg::SAT16 : fs_add[gwm_pkg::SUM_W-1:0];
				if (fi_b != gwm_pkg::SAT16) begin
					fi_n = fi_b + 16'd1;
				end
			end else begin
				stop_n = 1'b1;
			end
		end
		if (hb_b == '0 || !loaded) begin
			count = '0;
		end else if (fs_n < hb_b) begin
			count = fi_n;
		end else if (fi_n != '0) begin
			count = fi_n - 16'd1;
		end else begin
			count = '0;
		end
	end

	assign result.kind        = gwm_pkg::KIND_TEXT;
	assign result.total_width = ws_n;
	assign result.fit_count   = count;
	assign result.line_height = loaded ? height : 7'd0;
	assign result.loaded      = loaded;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_sum_q   <= '0;
			fit_sum_q     <= '0;
			fit_index_q   <= '0;
			fit_stopped_q <= 1'b0;
			held_bound_q  <= '0;
		end else if (fire) begin
			width_sum_q   <= ws_n;
			fit_sum_q     <= fs_n;
			fit_index_q   <= fi_n;
			fit_stopped_q <= stop_n;
			held_bound_q  <= hb_b;
		end
	end

endmodule

FILE: rtl/core/glyph_width_table_and_text_measure.sv
// ----------------------------------------------------------------------------
// Glyph width table and text measure
// Builds a 256-entry glyph width table from a streamed atlas and measures
// strings against it.
// ----------------------------------------------------------------------------
// Result path: input register, then width table read, then result register.
// Throughput: one beat per cycle while the result output is not stalled; the
// width table RAM is read once and written with one full glyph row per cycle,
// so atlas and text beats mix freely.
// Reset is asynchronous; per-row valid bits make the whole width table read
// as zero at once, with no clearing pass.
module glyph_width_table_and_text_measure (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic [7:0]  alpha,
	input  logic [7:0]  char_code,
	input  logic [15:0] bound,
	input  logic        first_char,
	input  logic        last_char,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [15:0] total_width,
	output logic [15:0] fit_count,
	output logic [6:0]  line_height,
	output logic        loaded
);

	logic                          valid_s1;
	logic                          opcode_s1;
	logic [7:0]                    alpha_s1;
	logic [7:0]                    code_s1;
	logic [15:0]                   bound_s1;
	logic                          first_s1;
	logic                          last_s1;
	logic                          valid_s2;
	logic                          opcode_s2;
	logic [gwm_pkg::CELL_AW-1:0]   col_s2;
	logic [15:0]                   bound_s2;
	logic                          first_s2;
	logic                          last_s2;
	logic                          rvalid_s2;
	logic                          ovr_s2;
	logic [gwm_pkg::GLYPH_W-1:0]   space_w_s2;
	logic                          pdone_s2;
	logic [6:0]                    height_s2;
	logic                          out_valid_q;
	gwm_pkg::gwm_result_t          out_q;
	logic                          s1_fire;
	logic                          s2_prod;
	logic                          s2_adv;
	logic                          s2_free;
	logic                          atlas_fire;
	logic                          ram_re;
	gwm_pkg::gwm_row_wr_t          row_wr;
	logic                          atlas_done;
	logic [6:0]                    step;
	gwm_pkg::gwm_atlas_stat_t      stat;
	logic [gwm_pkg::ROW_W-1:0]     row_rdata;
	logic [gwm_pkg::GLYPH_W-1:0]   row_glyphs [gwm_pkg::CELLS];
	logic [gwm_pkg::GLYPH_W-1:0]   glyph_s2;
	gwm_pkg::gwm_result_t          meas_res;
	gwm_pkg::gwm_result_t          atlas_res;

	assign s2_prod    = (opcode_s2 == gwm_pkg::OP_TEXT) ? last_s2 : pdone_s2;
	assign s2_adv     = valid_s2 && (!s2_prod || !out_valid_q || out_ready);
	assign s2_free    = !valid_s2 || s2_adv;
	assign s1_fire    = valid_s1 && s2_free;
	assign in_ready   = !valid_s1 || s1_fire;
	assign atlas_fire = s1_fire && (opcode_s1 == gwm_pkg::OP_ATLAS);
	assign ram_re     = s1_fire && (opcode_s1 == gwm_pkg::OP_TEXT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			opcode_s1 <= opcode;
			alpha_s1  <= alpha;
			code_s1   <= char_code;
			bound_s1  <= bound;
			first_s1  <= first_char;
			last_s1   <= last_char;
		end
	end

	gwm_atlas u_atlas (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.fire      (atlas_fire),
		.alpha     (alpha_s1),
		.row_wr    (row_wr),
		.done      (atlas_done),
		.step      (step),
		.stat      (stat)
	);

	gwm_ram #(
		.WIDTH (gwm_pkg::ROW_W),
		.DEPTH (gwm_pkg::CELLS)
	) u_width_ram (
		.clk   (clk),
		.we    (row_wr.we),
		.waddr (row_wr.addr),
		.wdata (row_wr.data),
		.re    (ram_re),
		.raddr (code_s1[7:4]),
		.rdata (row_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= s1_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			opcode_s2  <= opcode_s1;
			col_s2     <= code_s1[3:0];
			bound_s2   <= bound_s1;
			first_s2   <= first_s1;
			last_s2    <= last_s1;
			rvalid_s2  <= stat.row_valid[code_s1[7:4]];
			ovr_s2     <= stat.space_ovr && (code_s1 == gwm_pkg::SPACE_CODE);
			space_w_s2 <= stat.space_w;
			pdone_s2   <= atlas_done;
			height_s2  <= step;
		end
	end

	always_comb begin
		for (int x = 0; x < gwm_pkg::CELLS; x++) begin
			row_glyphs[x] = row_rdata[x*gwm_pkg::GLYPH_W +: gwm_pkg::GLYPH_W];
		end
		if (ovr_s2) begin
			glyph_s2 = space_w_s2;
		end else if (rvalid_s2) begin
			glyph_s2 = row_glyphs[col_s2];
		end else begin
			glyph_s2 = '0;
		end
	end

	gwm_measure u_measure (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (s2_adv && (opcode_s2 == gwm_pkg::OP_TEXT)),
		.first_char  (first_s2),
		.bound       (bound_s2),
		.glyph_width (glyph_s2),
		.loaded      (stat.loaded),
		.height      (stat.height),
		.result      (meas_res)
	);

	assign atlas_res.kind        = gwm_pkg::KIND_ATLAS;
	assign atlas_res.total_width = '0;
	assign atlas_res.fit_count   = '0;
	assign atlas_res.line_height = height_s2;
	assign atlas_res.loaded      = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_adv && s2_prod) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv && s2_prod) begin
			out_q <= (opcode_s2 == gwm_pkg::OP_TEXT) ? meas_res : atlas_res;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = out_q.kind;
	assign total_width = out_q.total_width;
	assign fit_count   = out_q.fit_count;
	assign line_height = out_q.line_height;
	assign loaded      = out_q.loaded;

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(row_wr.we && ram_re))
		else $error("width table written and read by the same beat");

	a_done_writes_row: assert property (@(posedge clk) disable iff (!arst_n)
		atlas_fire && atlas_done |-> row_wr.we)
		else $error("atlas end without a final row write");

	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		s2_adv && s2_prod |=> out_valid_q)
		else $error("result left stage two but output is empty");

	a_atlas_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.kind == gwm_pkg::KIND_ATLAS) |->
		out_q.loaded && (out_q.line_height != 7'd0) && (out_q.fit_count == '0))
		else $error("malformed atlas completion result");

	a_unloaded_fit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.loaded |-> (out_q.fit_count == '0) &&
		(out_q.line_height == 7'd0))
		else $error("fit count or height reported before any atlas load");

endmodule

FILE: dv/glyph_width_table_and_text_measure_tb.sv
// ----------------------------------------------------------------------------
// Glyph width table and text measure testbench
// Streams atlases at several cell sizes, measures strings against the
// resulting width table, and checks every result beat against a predictor
// of the width table, the fitting count and the load status.
// ----------------------------------------------------------------------------
module tb;

	localparam int WATCH_LIMIT = 2000;
	localparam int HOLD_CYCLES = 60;
	localparam int BEAT_TARGET = 740;

	class glyph_width_board;
		logic [6:0]            cell_reg;
		logic [6:0]            widths [256];
		int unsigned           lcol [gwm_pkg::CELLS];
		int unsigned           rcol [gwm_pkg::CELLS];
		bit                    seen [gwm_pkg::CELLS];
		int unsigned           px_col, px_row;
		bit                    done;
		int unsigned           wsum, fsum, findex;
		bit                    stopped;
		int unsigned           lim;
		logic [6:0]            height;
		gwm_pkg::gwm_result_t  due [$];
		int                    errors, beats, loads_checked, strings_checked;

		function new();
			cell_reg = gwm_pkg::RESET_CELL;
			foreach (widths[i]) widths[i] = '0;
			restart();
			done = 0;
			wsum = 0;
			fsum = 0;
			findex = 0;
			stopped = 0;
			lim = 0;
			height = '0;
			errors = 0;
			beats = 0;
			loads_checked = 0;
			strings_checked = 0;
		endfunction

		function void restart();
			px_col = 0;
			px_row = 0;
			foreach (seen[i]) begin
				seen[i] = 0;
				lcol[i] = 0;
				rcol[i] = 0;
			end
		endfunction

		function void set_cell(logic [6:0] v);
			cell_reg = v;
			restart();
		endfunction

		function void take_beat(logic op, logic [7:0] a, logic [7:0] code, logic [15:0] b,
				logic fm, logic lm);
			beats++;
			if (op == gwm_pkg::OP_ATLAS) begin
				advance_atlas(a);
			end else begin
				measure_char(code, b, fm, lm);
			end
		endfunction

		function void advance_atlas(logic [7:0] a);
			int unsigned st, side, cx, inner, cy;
			gwm_pkg::gwm_result_t r;
			st = (cell_reg == 0) ? 1 :
				((cell_reg > gwm_pkg::MAX_CELL) ? gwm_pkg::MAX_CELL : cell_reg);
			side = st * gwm_pkg::CELLS;
			cx = (px_col / st) % gwm_pkg::CELLS;
			inner = px_col % st;
			if (a != 0) begin
				if (!seen[cx]) begin
					seen[cx] = 1;
					lcol[cx] = inner;
					rcol[cx] = inner;
				end else begin
					if (inner < lcol[cx]) lcol[cx] = inner;
					if (inner > rcol[cx]) rcol[cx] = inner;
				end
			end
			if (px_col + 1 < side) begin
				px_col++;
				return;
			end
			px_col = 0;
			if (px_row % st == st - 1) begin
				cy = (px_row / st) % gwm_pkg::CELLS;
				for (int x = 0; x < gwm_pkg::CELLS; x++) begin
					widths[cy * gwm_pkg::CELLS + x] = seen[x] ? 7'(rcol[x] - lcol[x] + 1) : 7'd0;
					seen[x] = 0;
					lcol[x] = 0;
					rcol[x] = 0;
				end
			end
			if (px_row + 1 < side) begin
				px_row++;
				return;
			end
			px_row = 0;
			widths[gwm_pkg::SPACE_CODE] = 7'(st / 3);
			done = 1;
			height = 7'(st);
			r.kind = gwm_pkg::KIND_ATLAS;
			r.total_width = '0;
			r.fit_count = '0;
			r.line_height = height;
			r.loaded = 1'b1;
			due.push_back(r);
		endfunction

		function void measure_char(logic [7:0] code, logic [15:0] b, logic fm, logic lm);
			int unsigned w, count;
			gwm_pkg::gwm_result_t r;
			w = widths[code];
			if (fm) begin
				wsum = 0;
				fsum = 0;
				findex = 0;
				stopped = 0;
				lim = b;
			end
			wsum = (wsum + w > gwm_pkg::SAT16) ? gwm_pkg::SAT16 : wsum + w;
			if (!stopped) begin
				if (fsum < lim) begin
					fsum = (fsum + w > gwm_pkg::SAT16) ? gwm_pkg::SAT16 : fsum + w;
					if (findex < gwm_pkg::SAT16) findex++;
				end else begin
					stopped = 1;
				end
			end
			if (!lm) return;
			if (lim == 0 || !done) begin
				count = 0;
			end else if (fsum < lim) begin
				count = findex;
			end else begin
				count = (findex > 0) ? findex - 1 : 0;
			end
			r.kind = gwm_pkg::KIND_TEXT;
			r.total_width = 16'(wsum);
			r.fit_count = 16'(count);
			r.line_height = done ? height : 7'd0;
			r.loaded = done;
			due.push_back(r);
		endfunction

		function void check_result(gwm_pkg::gwm_result_t got);
			gwm_pkg::gwm_result_t want;
			if (due.size() == 0) begin
				$error("Result beat arrived with nothing expected (kind %0d).", got.kind);
				errors++;
				return;
			end
			want = due.pop_front();
			if (want.kind == gwm_pkg::KIND_ATLAS) loads_checked++;
			else strings_checked++;
			if (got.kind !== want.kind) begin
				$error("kind: expected %0d, got %0d", want.kind, got.kind);
				errors++;
			end
			if (got.total_width !== want.total_width) begin
				$error("total_width: expected %0d, got %0d", want.total_width, got.total_width);
				errors++;
			end
			if (got.fit_count !== want.fit_count) begin
				$error("fit_count: expected %0d, got %0d", want.fit_count, got.fit_count);
				errors++;
			end
			if (got.line_height !== want.line_height) begin
				$error("line_height: expected %0d, got %0d", want.line_height, got.line_height);
				errors++;
			end
			if (got.loaded !== want.loaded) begin
				$error("loaded: expected %0d, got %0d", want.loaded, got.loaded);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [6:0]  cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        opcode = 1'b0;
	logic [7:0]  alpha = '0;
	logic [7:0]  char_code = '0;
	logic [15:0] bound = '0;
	logic        first_char = 1'b0;
	logic        last_char = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        kind;
	logic [15:0] total_width;
	logic [15:0] fit_count;
	logic [6:0]  line_height;
	logic        loaded;

	glyph_width_board board;
	int tx_odds = 0;
	int rx_odds = 0;
	bit hold_ask = 1'b0;
	int cur_step = 16;

	glyph_width_table_and_text_measure dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.alpha(alpha),
		.char_code(char_code),
		.bound(bound),
		.first_char(first_char),
		.last_char(last_char),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.total_width(total_width),
		.fit_count(fit_count),
		.line_height(line_height),
		.loaded(loaded)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		gwm_pkg::gwm_result_t got;
		if (arst_n) begin
			if (cfg_we) board.set_cell(cfg_wdata);
			if (in_valid && in_ready) begin
				board.take_beat(opcode, alpha, char_code, bound, first_char, last_char);
			end
			if (out_valid && out_ready) begin
				got.kind = kind;
				got.total_width = total_width;
				got.fit_count = fit_count;
				got.line_height = line_height;
				got.loaded = loaded;
				board.check_result(got);
			end
		end
	end

	initial begin
		forever begin
			if (hold_ask) begin
				hold_ask = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (rx_odds != 0 && $urandom_range(1, rx_odds) == 1) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCH_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet = 0;
			else quiet++;
		end
		$display("tb: errors");
		$finish;
	end

	task automatic send_beat(input logic op, input logic [7:0] a, input logic [7:0] code,
			input logic [15:0] b, input logic fm, input logic lm);
		if (tx_odds != 0 && $urandom_range(1, tx_odds) == 1) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		alpha <= a;
		char_code <= code;
		bound <= b;
		first_char <= fm;
		last_char <= lm;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic send_text(input logic [7:0] code, input logic [15:0] b, input logic fm,
			input logic lm);
		send_beat(gwm_pkg::OP_TEXT, 8'($urandom), code, b, fm, lm);
	endtask

	task automatic send_pixel(input logic [7:0] a);
		send_beat(gwm_pkg::OP_ATLAS, a, 8'($urandom), 16'($urandom), 1'($urandom),
			1'($urandom));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.due.size() != 0) @(posedge clk);
	endtask

	task automatic write_cell(input logic [6:0] v);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_step = (v == 0) ? 1 : ((v > gwm_pkg::MAX_CELL) ? gwm_pkg::MAX_CELL : v);
	endtask

	task automatic random_string();
		int len;
		logic [15:0] b;
		logic [7:0] code;
		logic fm, lm;
		if ($urandom_range(0, 29) == 0) wait_drained();
		len = $urandom_range(1, 12);
		case ($urandom_range(0, 5))
			0: b = 16'd0;
			1: b = gwm_pkg::SAT16;
			2, 3: b = 16'($urandom_range(1, 60));
			4: b = 16'($urandom);
			default: b = 16'($urandom_range(1, 8));
		endcase
		for (int k = 0; k < len; k++) begin
			case ($urandom_range(0, 7))
				0: code = gwm_pkg::SPACE_CODE;
				1, 2: code = 8'($urandom_range(0, 15));
				default: code = 8'($urandom);
			endcase
			fm = ((k == 0) && $urandom_range(0, 9) != 0) || $urandom_range(0, 39) == 0;
			lm = (k == len - 1) && $urandom_range(0, 9) != 0;
			send_text(code, (k == 0) ? b : 16'($urandom), fm, lm);
		end
	endtask

	// Cell column 0 of every cell row is filled solid so that full-width glyphs always occur.
	task automatic feed_atlas(input int rows, input int odds);
		int side, cx, inner;
		int lo [gwm_pkg::CELLS];
		int hi [gwm_pkg::CELLS];
		bit on [gwm_pkg::CELLS];
		logic [7:0] a;
		side = cur_step * gwm_pkg::CELLS;
		for (int r = 0; r < rows; r++) begin
			if (r % cur_step == 0) begin
				for (int x = 0; x < gwm_pkg::CELLS; x++) begin
					on[x] = (x == 0) || $urandom_range(0, 4) != 0;
					lo[x] = $urandom_range(0, cur_step - 1);
					hi[x] = $urandom_range(lo[x], cur_step - 1);
					if (x == 0 || $urandom_range(0, 3) == 0) begin
						lo[x] = 0;
						hi[x] = cur_step - 1;
					end
				end
			end
			for (int c = 0; c < side; c++) begin
				cx = c / cur_step;
				inner = c % cur_step;
				a = 8'd0;
				if (on[cx] && inner >= lo[cx] && inner <= hi[cx]) begin
					if (cx == 0 || $urandom_range(0, 3) != 0) begin
						a = ($urandom_range(0, 15) == 0) ? 8'hFF : 8'($urandom_range(1, 255));
					end
				end
				send_pixel(a);
				if (odds > 0 && $urandom_range(1, odds) == 1) random_string();
			end
		end
	endtask

	initial begin
		int n;
		board = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_odds = 5;
		rx_odds = 5;
		send_text(8'd65, 16'd100, 1'b0, 1'b1);
		send_text(8'd65, gwm_pkg::SAT16, 1'b1, 1'b0);
		send_text(8'd66, 16'd0, 1'b0, 1'b1);
		send_text(8'd255, 16'd0, 1'b1, 1'b1);

		write_cell(7'd0);
		feed_atlas(gwm_pkg::CELLS, 40);
		send_text(gwm_pkg::SPACE_CODE, gwm_pkg::SAT16, 1'b1, 1'b1);
		send_text(8'd0, 16'd1, 1'b1, 1'b0);
		send_text(8'd255, 16'd0, 1'b0, 1'b0);
		send_text(gwm_pkg::SPACE_CODE, 16'd0, 1'b0, 1'b0);
		send_text(8'd97, 16'd0, 1'b0, 1'b1);
		send_text(8'd10, 16'd0, 1'b1, 1'b1);
		send_text(8'd7, 16'd3, 1'b0, 1'b1);
		wait_drained();
		n = board.widths[65] + board.widths[66];
		send_text(8'd65, 16'(n), 1'b1, 1'b0);
		send_text(8'd66, 16'hFFFF, 1'b0, 1'b0);
		send_text(8'd67, 16'd0, 1'b0, 1'b1);

		write_cell(7'd127);
		for (int k = 0; k < 40; k++) send_pixel(8'($urandom));
		write_cell(7'd3);
		tx_odds = 4;
		rx_odds = 7;
		feed_atlas(cur_step, 20);
		write_cell(7'd1);
		feed_atlas(3 * cur_step, 0);
		send_text(gwm_pkg::SPACE_CODE, 16'd2, 1'b1, 1'b0);
		send_text(gwm_pkg::SPACE_CODE, 16'd0, 1'b0, 1'b1);

		hold_ask = 1'b1;
		for (int k = 0; k < 40; k++) send_text(8'($urandom), 16'($urandom), 1'b1, 1'b1);
		wait_drained();

		tx_odds = 0;
		rx_odds = 0;
		while (board.beats < BEAT_TARGET) random_string();

		wait_drained();
		repeat (8) @(posedge clk);
		if (board.due.size() != 0) begin
			$error("%0d expected results never arrived.", board.due.size());
			board.errors++;
		end
		$display("summary: %0d beats in, %0d atlas loads and %0d string results checked",
			board.beats, board.loads_checked, board.strings_checked);
		$display("summary: cell sizes 0, 1, 3 and 127, restarts, partial reloads, space glyph");
		if (board.errors == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule
